// ----- rtl/mfs_pkg.sv -----
package mfs_pkg;

   // input operation codes
   localparam logic OP_ARRIVE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_ZERO    = 2'd2;
   localparam logic [1:0] STATUS_DROPPED = 2'd3;

   // item classes handed from front to back
   localparam logic [1:0] KIND_ARRIVE = 2'd0;
   localparam logic [1:0] KIND_REJECT = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;

   localparam logic [2:0] LEVEL_IDLE = 3'd0;
   localparam logic [2:0] LEVEL_TOP  = 3'd5;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  id;
      logic [15:0] length;
   } item_type;

   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] remaining;
      logic [31:0] arrival;
   } job_type;

   localparam int JOB_W = $bits(job_type);

   // time slice granted on entry to a level
   function automatic logic [4:0] quantum(input logic [2:0] lvl);
      logic [4:0] q;
      case (lvl)
         3'd5:    q = 5'd1;
         3'd4:    q = 5'd2;
         3'd3:    q = 5'd4;
         3'd2:    q = 5'd8;
         3'd1:    q = 5'd16;
         default: q = 5'd0;
      endcase
      return q;
   endfunction

endpackage

// ----- rtl/mfs_ram.sv -----
module mfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/mfs_front.sv -----
module mfs_front
   import mfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_job_id,
   input  logic [15:0] req_job_length,
   output logic        item_valid,
   input  logic        item_ready,
   output item_type    item
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   cls;
   logic       push, pop;

   // classify the incoming beat
   always_comb begin
      cls.id     = req_job_id;
      cls.length = req_job_length;
      if (req_op == OP_TICK) begin
         cls.kind = KIND_TICK;
      end else if (req_job_length == 16'd0) begin
         cls.kind = KIND_REJECT;
      end else begin
         cls.kind = KIND_ARRIVE;
      end
   end

   assign req_ready  = (cnt_ff != 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   // two-entry queue between front and back
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ----- rtl/mfs_back.sv -----
module mfs_back
   import mfs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             item_valid,
   output logic                             item_ready,
   input  item_type                         item,
   output logic                             ram_we,
   output logic [$clog2(5*QUEUE_DEPTH)-1:0] ram_waddr,
   output job_type                          ram_wdata,
   output logic [$clog2(5*QUEUE_DEPTH)-1:0] ram_raddr,
   input  job_type                          ram_rdata,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_busy_res,
   output logic [7:0]                       rsp_run_id,
   output logic [2:0]                       rsp_run_level,
   output logic                             rsp_done_res,
   output logic [31:0]                      rsp_turnaround
);

   localparam int D  = QUEUE_DEPTH;
   localparam int PW = (D > 1) ? $clog2(D) : 1;
   localparam int CW = $clog2(D + 1);
   localparam int AW = $clog2(5 * D);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DEM  = 3'd1;
   localparam logic [2:0] ST_PICK = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_RUN  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [PW-1:0] head_ff [1:5];
   logic [PW-1:0] head_in [1:5];
   logic [CW-1:0] count_ff [1:5];
   logic [CW-1:0] count_in [1:5];
   job_type       pause_job_ff [1:4];
   job_type       pause_job_in [1:4];
   logic [4:0]    pause_slice_ff [1:4];
   logic [4:0]    pause_slice_in [1:4];
   logic [4:1]    pvalid_ff, pvalid_in;
   job_type       run_job_ff, run_job_in;
   logic [4:0]    slice_ff, slice_in;
   logic [2:0]    run_lvl_ff, run_lvl_in;
   logic [31:0]   tick_ff, tick_in;
   logic          pop_ff, pop_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [1:0]    status_ff, status_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    o_status_ff, o_status_in;
   logic          o_busy_ff, o_busy_in;
   logic [7:0]    o_id_ff, o_id_in;
   logic [2:0]    o_lvl_ff, o_lvl_in;
   logic          o_done_ff, o_done_in;
   logic [31:0]   o_tat_ff, o_tat_in;

   logic          out_free;
   logic [2:0]    tgt, wlvl, hsel;
   logic [CW:0]   tail_sum;
   logic [PW-1:0] tail;
   logic          wfull, found, was_idle, from_pause;
   logic [5:1]    lvl_ready;
   job_type       cur_job;
   logic [15:0]   rem_next;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign item_ready = (state_ff == ST_IDLE) && (item.kind == KIND_TICK || out_free);
   assign ram_raddr  = addr_ff;

   // push target: top level on arrival, next level down on demotion (level 1 stays at level 1)
   always_comb begin
      tgt      = (run_lvl_ff > 3'd1) ? run_lvl_ff - 3'd1 : 3'd1;
      wlvl     = (state_ff == ST_DEM) ? tgt : LEVEL_TOP;
      tail_sum = (CW + 1)'(head_ff[wlvl]) + (CW + 1)'(count_ff[wlvl]);
      tail     = (tail_sum >= (CW + 1)'(D)) ? PW'(tail_sum - (CW + 1)'(D)) : PW'(tail_sum);
      wfull    = (count_ff[wlvl] == CW'(D));
   end

   // highest ready level above the running one
   always_comb begin
      lvl_ready[5] = (count_ff[5] != '0);
      for (int h = 1; h <= 4; h++) begin
         lvl_ready[h] = pvalid_ff[h] || (count_ff[h] != '0);
      end
      found = 1'b0;
      hsel  = LEVEL_IDLE;
      for (int h = 1; h <= 5; h++) begin
         if (lvl_ready[h] && 3'(h) > run_lvl_ff) begin
            found = 1'b1;
            hsel  = 3'(h);
         end
      end
      was_idle   = (run_lvl_ff == LEVEL_IDLE);
      from_pause = (hsel <= 3'd4) && (hsel != LEVEL_IDLE) && pvalid_ff[hsel[2:0]];
   end

   assign cur_job  = pop_ff ? ram_rdata : run_job_ff;
   assign rem_next = cur_job.remaining - 16'd1;

   // arrival handling and tick sequencer: demote, pick, fetch, run
   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      pause_job_in   = pause_job_ff;
      pause_slice_in = pause_slice_ff;
      pvalid_in      = pvalid_ff;
      run_job_in     = run_job_ff;
      slice_in       = slice_ff;
      run_lvl_in     = run_lvl_ff;
      tick_in        = tick_ff;
      pop_in         = pop_ff;
      addr_in        = addr_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      o_status_in    = o_status_ff;
      o_busy_in      = o_busy_ff;
      o_id_in        = o_id_ff;
      o_lvl_in       = o_lvl_ff;
      o_done_in      = o_done_ff;
      o_tat_in       = o_tat_ff;
      ram_we         = 1'b0;
      ram_waddr      = AW'(AW'(wlvl - 3'd1) * AW'(D)) + AW'(tail);
      ram_wdata      = run_job_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid && item_ready) begin
               if (item.kind == KIND_TICK) begin
                  status_in = STATUS_OK;
                  state_in  = ST_DEM;
               end else begin
                  ram_wdata.id        = item.id;
                  ram_wdata.remaining = item.length;
                  ram_wdata.arrival   = tick_ff;
                  if (item.kind == KIND_REJECT) begin
                     o_status_in = STATUS_ZERO;
                  end else if (wfull) begin
                     o_status_in = STATUS_FULL;
                  end else begin
                     o_status_in    = STATUS_OK;
                     ram_we         = 1'b1;
                     count_in[5]    = count_ff[5] + CW'(1);
                  end
                  rsp_valid_in = 1'b1;
                  o_busy_in    = 1'b0;
                  o_id_in      = 8'd0;
                  o_lvl_in     = LEVEL_IDLE;
                  o_done_in    = 1'b0;
                  o_tat_in     = 32'd0;
               end
            end
         end
         ST_DEM: begin
            if (run_lvl_ff != LEVEL_IDLE && slice_ff == 5'd0) begin
               if (wfull) begin
                  status_in = STATUS_DROPPED;
               end else begin
                  ram_we        = 1'b1;
                  count_in[tgt] = count_ff[tgt] + CW'(1);
               end
               run_lvl_in = LEVEL_IDLE;
            end
            state_in = ST_PICK;
         end
         ST_PICK: begin
            state_in = ST_RUN;
            if (found) begin
               if (!was_idle) begin
                  pause_job_in[run_lvl_ff]   = run_job_ff;
                  pause_slice_in[run_lvl_ff] = slice_ff;
                  pvalid_in[run_lvl_ff]      = 1'b1;
               end
               run_lvl_in = hsel;
               if (from_pause) begin
                  run_job_in      = pause_job_ff[hsel];
                  slice_in        = was_idle ? pause_slice_ff[hsel] : quantum(hsel);
                  pvalid_in[hsel] = 1'b0;
               end else begin
                  addr_in       = AW'(AW'(hsel - 3'd1) * AW'(D)) + AW'(head_ff[hsel]);
                  head_in[hsel] = (head_ff[hsel] == PW'(D - 1)) ? '0
                                  : head_ff[hsel] + PW'(1);
                  count_in[hsel] = count_ff[hsel] - CW'(1);
                  slice_in       = quantum(hsel);
                  pop_in         = 1'b1;
                  state_in       = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (out_free) begin
               pop_in       = 1'b0;
               rsp_valid_in = 1'b1;
               o_status_in  = status_ff;
               o_busy_in    = 1'b0;
               o_id_in      = 8'd0;
               o_lvl_in     = LEVEL_IDLE;
               o_done_in    = 1'b0;
               o_tat_in     = 32'd0;
               run_job_in   = cur_job;
               if (run_lvl_ff != LEVEL_IDLE) begin
                  o_busy_in            = 1'b1;
                  o_id_in              = cur_job.id;
                  o_lvl_in             = run_lvl_ff;
                  run_job_in.remaining = rem_next;
                  if (rem_next == 16'd0) begin
                     o_done_in  = 1'b1;
                     o_tat_in   = tick_ff + 32'd1 - cur_job.arrival;
                     run_lvl_in = LEVEL_IDLE;
                     slice_in   = 5'd0;
                  end else begin
                     slice_in = slice_ff - 5'd1;
                  end
               end
               tick_in  = tick_ff + 32'd1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '{default: '0};
         count_ff     <= '{default: '0};
         pvalid_ff    <= '0;
         run_job_ff   <= '0;
         slice_ff     <= 5'd0;
         run_lvl_ff   <= LEVEL_IDLE;
         tick_ff      <= 32'd0;
         pop_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pvalid_ff    <= pvalid_in;
         run_job_ff   <= run_job_in;
         slice_ff     <= slice_in;
         run_lvl_ff   <= run_lvl_in;
         tick_ff      <= tick_in;
         pop_ff       <= pop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pause_job_ff   <= pause_job_in;
      pause_slice_ff <= pause_slice_in;
      addr_ff        <= addr_in;
      status_ff      <= status_in;
      o_status_ff    <= o_status_in;
      o_busy_ff      <= o_busy_in;
      o_id_ff        <= o_id_in;
      o_lvl_ff       <= o_lvl_in;
      o_done_ff      <= o_done_in;
      o_tat_ff       <= o_tat_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = o_status_ff;
   assign rsp_busy_res   = o_busy_ff;
   assign rsp_run_id     = o_id_ff;
   assign rsp_run_level  = o_lvl_ff;
   assign rsp_done_res   = o_done_ff;
   assign rsp_turnaround = o_tat_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff[5] <= CW'(D))
      else $error("top level count past depth");

   a_read_has_pop: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> pop_ff)
      else $error("fetch state without a pending pop");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && o_done_ff |-> o_busy_ff && o_lvl_ff != LEVEL_IDLE)
      else $error("completion reported without a running job");

   a_run_no_pause_self: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN && run_lvl_ff != LEVEL_IDLE && run_lvl_ff != LEVEL_TOP
      |-> !pvalid_ff[run_lvl_ff])
      else $error("running level also holds a paused job");

endmodule

// ----- rtl/multilevel_feedback_scheduler_top.sv -----
// Five-level feedback scheduler.
// Input channel req_*: one beat is either an arrival (req_op = 0, with
// req_job_id and req_job_length) or a time tick (req_op = 1).
// Result channel rsp_*: exactly one beat per input beat, in order, with
// status, the job that ran on a tick, its level, completion flag and
// turnaround.
// A two-entry queue decouples the classifier from the execution sequencer.
// An arrival is handled in the sequencer's idle state; a tick steps through
// demote, pick, job store read and run (the read is skipped when no job
// comes from the store). Each item first passes through the registered queue.
// Throughput is one arrival per cycle while the result channel is not
// stalled; a tick is taken and then stepped through demote, pick, fetch
// and run before the sequencer takes the next item.
// Reset clears all levels, pause slots, the running job and the tick
// counter; the job store itself needs no clearing.
// When rsp_ready is low the result is held in the output register, the
// sequencer waits before completing its next item, and req_ready drops
// once the two-entry queue is full.
module multilevel_feedback_scheduler_top
   import mfs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_job_id,
   input  logic [15:0] req_job_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_busy_res,
   output logic [7:0]  rsp_run_id,
   output logic [2:0]  rsp_run_level,
   output logic        rsp_done_res,
   output logic [31:0] rsp_turnaround
);

   localparam int AW = $clog2(5 * QUEUE_DEPTH);

   item_type      item;
   logic          item_valid, item_ready;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   job_type       ram_wdata, ram_rdata;

   mfs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_job_id     (req_job_id),
      .req_job_length (req_job_length),
      .item_valid     (item_valid),
      .item_ready     (item_ready),
      .item           (item)
   );

   mfs_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid),
      .item_ready     (item_ready),
      .item           (item),
      .ram_we         (ram_we),
      .ram_waddr      (ram_waddr),
      .ram_wdata      (ram_wdata),
      .ram_raddr      (ram_raddr),
      .ram_rdata      (ram_rdata),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_run_id     (rsp_run_id),
      .rsp_run_level  (rsp_run_level),
      .rsp_done_res   (rsp_done_res),
      .rsp_turnaround (rsp_turnaround)
   );

   // job store: five level FIFOs side by side
   mfs_ram #(.WIDTH(JOB_W), .DEPTH(5 * QUEUE_DEPTH)) u_job_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule
